// File: rtl/nhhc_pkg.sv
`default_nettype none

package nhhc_pkg;

  localparam int MAX_NODES   = 64;
  localparam int ID_W        = 7;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int IDX_W       = $clog2(MAX_NODES);
  localparam int RADDR_W     = 2 * IDX_W;
  localparam int ROUTE_DEPTH = MAX_NODES * MAX_NODES;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_NODE_COUNT = 1'b0;
  localparam logic [ID_W-1:0] NODE_COUNT_RESET = ID_W'(64);

  localparam logic [CMD_W-1:0] CMD_SET_DEFAULT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR_DEFAULT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_ROUTE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_ROUTE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HOP_QUERY     = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_APPLIED     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_APPLIED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FOUND       = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_ROUTE    = 2'd3;

  typedef struct packed {
    logic               route_we;
    logic [RADDR_W-1:0] route_waddr;
    logic [ID_W-1:0]    route_wdata;
    logic [RADDR_W-1:0] route_raddr;
    logic               def_we;
    logic [IDX_W-1:0]   def_waddr;
    logic [ID_W-1:0]    def_wdata;
    logic [IDX_W-1:0]   def_raddr;
  } mem_req_t;

  function automatic logic [ID_W-1:0] norm_id(input logic [ID_W-1:0] id,
                                              input logic [ID_W-1:0] n);
    logic [ID_W-1:0] r;
    r = (id != '0 && id <= n) ? id : '0;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] id_index(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] m;
    m = id - ID_W'(1);
    return m[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/nhhc_if.sv
`default_nettype none

interface nhhc_req_if;
  logic                        valid;
  logic                        ready;
  logic [nhhc_pkg::CMD_W-1:0]  command;
  logic [nhhc_pkg::ID_W-1:0]   node;
  logic [nhhc_pkg::ID_W-1:0]   destination;
  logic [nhhc_pkg::ID_W-1:0]   next_hop;

  modport source (output valid, command, node, destination, next_hop, input ready);
  modport sink (input valid, command, node, destination, next_hop, output ready);
endinterface

interface nhhc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [nhhc_pkg::STATUS_W-1:0] status;
  logic [nhhc_pkg::ID_W-1:0]     hop_count;

  modport source (output valid, status, hop_count, input ready);
  modport sink (input valid, status, hop_count, output ready);
endinterface

`default_nettype wire

// File: rtl/nhhc_mem.sv
`default_nettype none

module nhhc_mem (
  input  wire logic                          clk,
  input  wire nhhc_pkg::mem_req_t            mem_req,
  output logic [nhhc_pkg::ID_W-1:0]          route_rdata,
  output logic [nhhc_pkg::ID_W-1:0]          def_rdata
);

  logic [nhhc_pkg::ID_W-1:0] route_mem [nhhc_pkg::ROUTE_DEPTH];
  logic [nhhc_pkg::ID_W-1:0] def_mem [nhhc_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (mem_req.route_we) begin
      route_mem[mem_req.route_waddr] <= mem_req.route_wdata;
    end
    route_rdata <= route_mem[mem_req.route_raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_req.def_we) begin
      def_mem[mem_req.def_waddr] <= mem_req.def_wdata;
    end
    def_rdata <= def_mem[mem_req.def_raddr];
  end

endmodule

`default_nettype wire

// File: rtl/nhhc_ctrl.sv
`default_nettype none

module nhhc_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [nhhc_pkg::ID_W-1:0]  n_eff,
  nhhc_req_if.sink                        req,
  nhhc_rsp_if.source                      rsp,
  output nhhc_pkg::mem_req_t              mem_req,
  input  wire logic [nhhc_pkg::ID_W-1:0]  route_rdata,
  input  wire logic [nhhc_pkg::ID_W-1:0]  def_rdata
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_RESP} state_t;

  state_t                          state;
  logic [nhhc_pkg::CMD_W-1:0]      cmd_q;
  logic [nhhc_pkg::ID_W-1:0]       node_q;
  logic [nhhc_pkg::ID_W-1:0]       dest_q;
  logic [nhhc_pkg::ID_W-1:0]       hop_q;
  logic [nhhc_pkg::ID_W-1:0]       n_q;
  logic [nhhc_pkg::ID_W-1:0]       count;
  logic [nhhc_pkg::RADDR_W-1:0]    clr_addr;
  logic [nhhc_pkg::STATUS_W-1:0]   res_status;
  logic [nhhc_pkg::ID_W-1:0]       res_hops;
  logic                            out_valid;
  logic [nhhc_pkg::STATUS_W-1:0]   out_status;
  logic [nhhc_pkg::ID_W-1:0]       out_hops;

  logic [nhhc_pkg::ID_W-1:0]       in_node;
  logic [nhhc_pkg::ID_W-1:0]       in_dest;
  logic [nhhc_pkg::ID_W-1:0]       nh_raw;
  logic [nhhc_pkg::ID_W-1:0]       nh;
  logic [nhhc_pkg::ID_W-1:0]       count_inc;
  logic [nhhc_pkg::ID_W-1:0]       cur_sel;
  logic [nhhc_pkg::ID_W-1:0]       dest_sel;
  logic                            node_ok;
  logic                            pair_ok;
  logic                            upd_apply;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.hop_count = out_hops;

  assign in_node   = nhhc_pkg::norm_id(req.node, n_eff);
  assign in_dest   = nhhc_pkg::norm_id(req.destination, n_eff);
  assign nh_raw    = (route_rdata != '0) ? route_rdata : def_rdata;
  assign nh        = (nh_raw > n_q) ? '0 : nh_raw;
  assign count_inc = count + nhhc_pkg::ID_W'(1);
  assign node_ok   = (node_q != '0);
  assign pair_ok   = node_ok && (dest_q != '0);
  assign cur_sel   = (state == S_IDLE) ? in_node : nh;
  assign dest_sel  = (state == S_IDLE) ? in_dest : dest_q;

  always_comb begin
    upd_apply = 1'b0;
    unique case (cmd_q)
      nhhc_pkg::CMD_SET_DEFAULT:   upd_apply = node_ok;
      nhhc_pkg::CMD_CLEAR_DEFAULT: upd_apply = node_ok && (def_rdata == hop_q);
      nhhc_pkg::CMD_ADD_ROUTE:     upd_apply = pair_ok && (route_rdata == '0);
      nhhc_pkg::CMD_REMOVE_ROUTE:  upd_apply = pair_ok && (route_rdata == hop_q);
      default:                     upd_apply = 1'b0;
    endcase
  end

  always_comb begin
    mem_req             = '0;
    mem_req.route_raddr = {nhhc_pkg::id_index(cur_sel), nhhc_pkg::id_index(dest_sel)};
    mem_req.def_raddr   = nhhc_pkg::id_index(cur_sel);
    if (state == S_CLEAR) begin
      mem_req.route_we    = 1'b1;
      mem_req.route_waddr = clr_addr;
      mem_req.def_we      = (clr_addr[nhhc_pkg::RADDR_W-1:nhhc_pkg::IDX_W] == '0);
      mem_req.def_waddr   = clr_addr[nhhc_pkg::IDX_W-1:0];
    end else if (state == S_EXEC && upd_apply) begin
      mem_req.route_waddr = {nhhc_pkg::id_index(node_q), nhhc_pkg::id_index(dest_q)};
      mem_req.def_waddr   = nhhc_pkg::id_index(node_q);
      unique case (cmd_q)
        nhhc_pkg::CMD_SET_DEFAULT: begin
          mem_req.def_we    = 1'b1;
          mem_req.def_wdata = hop_q;
        end
        nhhc_pkg::CMD_CLEAR_DEFAULT: begin
          mem_req.def_we = 1'b1;
        end
        nhhc_pkg::CMD_ADD_ROUTE: begin
          mem_req.route_we    = 1'b1;
          mem_req.route_wdata = hop_q;
        end
        nhhc_pkg::CMD_REMOVE_ROUTE: begin
          mem_req.route_we = 1'b1;
        end
        default: begin
          mem_req.route_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + nhhc_pkg::RADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cmd_q  <= req.command;
            node_q <= in_node;
            dest_q <= in_dest;
            hop_q  <= nhhc_pkg::norm_id(req.next_hop, n_eff);
            n_q    <= n_eff;
            count  <= '0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_q == nhhc_pkg::CMD_HOP_QUERY) begin
            if (!pair_ok) begin
              res_status <= nhhc_pkg::STAT_NO_ROUTE;
              res_hops   <= '0;
              state      <= S_RESP;
            end else if (node_q == dest_q) begin
              res_status <= nhhc_pkg::STAT_FOUND;
              res_hops   <= '0;
              state      <= S_RESP;
            end else if (nh == dest_q) begin
              res_status <= nhhc_pkg::STAT_FOUND;
              res_hops   <= count_inc;
              state      <= S_RESP;
            end else if (nh == '0 || count_inc >= n_q) begin
              res_status <= nhhc_pkg::STAT_NO_ROUTE;
              res_hops   <= '0;
              state      <= S_RESP;
            end else begin
              count <= count_inc;
            end
          end else begin
            res_status <= upd_apply ? nhhc_pkg::STAT_APPLIED : nhhc_pkg::STAT_NOT_APPLIED;
            res_hops   <= '0;
            state      <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_hops   <= res_hops;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rsp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESP))
    else $error("result raised outside the response state");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> (count < n_q || count == '0))
    else $error("hop walk ran past the node count");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    (mem_req.route_we || mem_req.def_we) |-> (state == S_CLEAR || state == S_EXEC))
    else $error("table write outside clear or execute");

  a_found_hops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != nhhc_pkg::STAT_FOUND) |-> (out_hops == '0))
    else $error("nonzero hop count without a found route");

endmodule

`default_nettype wire

// File: rtl/next_hop_table_hop_counter_core.sv
// next hop table with hop counter
// req channel: command, node, destination, next_hop; a transfer is valid && ready
// rsp channel: status, hop_count; one result per request, in request order
// apb port: node_count at byte address 0, pready tied high, read returns the value
// commands: set/clear default hop, add/remove route, hop count query
// tables: route table of max_nodes * max_nodes entries and a default-hop table,
//   both in single-read single-write memories with a registered read
// updates: read, then conditional write back; a request passes through the execute
//   and response states, its result is registered on leaving the response state
// queries: one table read per hop, at most min(node_count, 64) hops; the
//   read-to-address loop sets the rate
// one request is in flight at a time, so reads never see a pending write
// reset: a clearing pass over all 4096 route addresses zeroes both tables;
//   req.ready stays low during it, apb writes are taken as usual
// a stalled rsp holds its result; the next request may be taken meanwhile and
//   its result waits until the output register frees up
`default_nettype none

module next_hop_table_hop_counter_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [nhhc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [nhhc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nhhc_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready,
  nhhc_req_if.sink                                 req,
  nhhc_rsp_if.source                               rsp
);

  logic [nhhc_pkg::ID_W-1:0] node_count;
  logic [nhhc_pkg::ID_W-1:0] n_eff;
  logic                      reg_sel;
  nhhc_pkg::mem_req_t        mem_req;
  logic [nhhc_pkg::ID_W-1:0] route_rdata;
  logic [nhhc_pkg::ID_W-1:0] def_rdata;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[nhhc_pkg::APB_ADDR_W-1:2] == nhhc_pkg::REG_NODE_COUNT);
  assign prdata  = reg_sel ? nhhc_pkg::APB_DATA_W'(node_count) : '0;
  assign n_eff   = (node_count < nhhc_pkg::ID_W'(nhhc_pkg::MAX_NODES)) ?
                   node_count : nhhc_pkg::ID_W'(nhhc_pkg::MAX_NODES);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= nhhc_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      node_count <= pwdata[nhhc_pkg::ID_W-1:0];
    end
  end

  nhhc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .n_eff       (n_eff),
    .req         (req),
    .rsp         (rsp),
    .mem_req     (mem_req),
    .route_rdata (route_rdata),
    .def_rdata   (def_rdata)
  );

  nhhc_mem u_mem (
    .clk         (clk),
    .mem_req     (mem_req),
    .route_rdata (route_rdata),
    .def_rdata   (def_rdata)
  );

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic [nhhc_pkg::STATUS_W-1:0] status;
    logic [nhhc_pkg::ID_W-1:0]     hops;
  } answer_t;

  class route_scoreboard;
    logic [nhhc_pkg::ID_W-1:0] route_tab [nhhc_pkg::ROUTE_DEPTH];
    logic [nhhc_pkg::ID_W-1:0] def_tab [nhhc_pkg::MAX_NODES];
    logic [nhhc_pkg::ID_W-1:0] node_count;
    answer_t                   pending_answers [$];
    int                        failures;

    function new();
      foreach (route_tab[i]) route_tab[i] = '0;
      foreach (def_tab[i]) def_tab[i] = '0;
      node_count = nhhc_pkg::NODE_COUNT_RESET;
      failures = 0;
    endfunction

    function int limit();
      return (node_count > nhhc_pkg::MAX_NODES) ? nhhc_pkg::MAX_NODES : int'(node_count);
    endfunction

    function logic [nhhc_pkg::ID_W-1:0] known_id(logic [nhhc_pkg::ID_W-1:0] id);
      return (id >= 1 && id <= limit()) ? id : '0;
    endfunction

    function int slot(logic [nhhc_pkg::ID_W-1:0] nd, logic [nhhc_pkg::ID_W-1:0] dst);
      return (int'(nd) - 1) * nhhc_pkg::MAX_NODES + int'(dst) - 1;
    endfunction

    function logic [nhhc_pkg::ID_W-1:0] route_at(logic [nhhc_pkg::ID_W-1:0] nd,
                                                 logic [nhhc_pkg::ID_W-1:0] dst);
      if (known_id(nd) == 0 || known_id(dst) == 0) return '0;
      return route_tab[slot(nd, dst)];
    endfunction

    function logic [nhhc_pkg::ID_W-1:0] default_at(logic [nhhc_pkg::ID_W-1:0] nd);
      if (known_id(nd) == 0) return '0;
      return def_tab[nd - 1];
    endfunction

    function answer_t resolve(logic [nhhc_pkg::CMD_W-1:0] cmd,
                              logic [nhhc_pkg::ID_W-1:0] nd_in,
                              logic [nhhc_pkg::ID_W-1:0] dst_in,
                              logic [nhhc_pkg::ID_W-1:0] hop_in);
      answer_t                   a;
      int                        n;
      int                        count;
      logic [nhhc_pkg::ID_W-1:0] nd, dst, hop, cur, nh;
      n = limit();
      nd = known_id(nd_in);
      dst = known_id(dst_in);
      hop = known_id(hop_in);
      a.status = nhhc_pkg::STAT_NOT_APPLIED;
      a.hops = '0;
      case (cmd)
        nhhc_pkg::CMD_SET_DEFAULT: begin
          if (nd != 0) begin
            def_tab[nd - 1] = hop;
            a.status = nhhc_pkg::STAT_APPLIED;
          end
        end
        nhhc_pkg::CMD_CLEAR_DEFAULT: begin
          if (nd != 0 && def_tab[nd - 1] == hop) begin
            def_tab[nd - 1] = '0;
            a.status = nhhc_pkg::STAT_APPLIED;
          end
        end
        nhhc_pkg::CMD_ADD_ROUTE: begin
          if (nd != 0 && dst != 0 && route_tab[slot(nd, dst)] == 0) begin
            route_tab[slot(nd, dst)] = hop;
            a.status = nhhc_pkg::STAT_APPLIED;
          end
        end
        nhhc_pkg::CMD_REMOVE_ROUTE: begin
          if (nd != 0 && dst != 0 && route_tab[slot(nd, dst)] == hop) begin
            route_tab[slot(nd, dst)] = '0;
            a.status = nhhc_pkg::STAT_APPLIED;
          end
        end
        nhhc_pkg::CMD_HOP_QUERY: begin
          a.status = nhhc_pkg::STAT_NO_ROUTE;
          if (nd != 0 && dst != 0) begin
            if (nd == dst) begin
              a.status = nhhc_pkg::STAT_FOUND;
            end else begin
              cur = nd;
              count = 0;
              do begin
                nh = '0;
                if (cur >= 1 && cur <= n) begin
                  nh = route_tab[slot(cur, dst)];
                  if (nh == 0) nh = def_tab[cur - 1];
                  if (nh > n) nh = '0;
                end
                count++;
                cur = nh;
              end while (nh != dst && nh != 0 && count < n);
              if (nh == dst) begin
                a.status = nhhc_pkg::STAT_FOUND;
                a.hops = nhhc_pkg::ID_W'(count);
              end
            end
          end
        end
        default: ;
      endcase
      return a;
    endfunction

    function void note_request(logic [nhhc_pkg::CMD_W-1:0] cmd,
                               logic [nhhc_pkg::ID_W-1:0] nd,
                               logic [nhhc_pkg::ID_W-1:0] dst,
                               logic [nhhc_pkg::ID_W-1:0] hop);
      pending_answers.push_back(resolve(cmd, nd, dst, hop));
    endfunction

    function void check_result(logic [nhhc_pkg::STATUS_W-1:0] status,
                               logic [nhhc_pkg::ID_W-1:0] hops);
      answer_t a;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result status %0d hops %0d", $time, status, hops);
        failures++;
        return;
      end
      a = pending_answers.pop_front();
      if (status !== a.status) begin
        $display("%0t: status expected %0d actual %0d", $time, a.status, status);
        failures++;
      end
      if (hops !== a.hops) begin
        $display("%0t: hop_count expected %0d actual %0d", $time, a.hops, hops);
        failures++;
      end
    endfunction

    function int outstanding();
      return pending_answers.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [nhhc_pkg::APB_ADDR_W-1:0] paddr;
  logic [nhhc_pkg::APB_DATA_W-1:0] pwdata;
  logic [nhhc_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  nhhc_req_if req ();
  nhhc_rsp_if rsp ();

  route_scoreboard sb = new();
  int src_idle_pct = 9;
  int sink_idle_pct = 85;
  bit stall_request = 0;
  int idle_cycles = 0;

  next_hop_table_hop_counter_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req),
    .rsp     (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        sb.note_request(req.command, req.node, req.destination, req.next_hop);
      end
      if (rsp.valid && rsp.ready) begin
        sb.check_result(rsp.status, rsp.hop_count);
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result receiver with random stalls and a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // starts and ends at a falling edge; valid stays high after the transfer
  task automatic send(input logic [nhhc_pkg::CMD_W-1:0] cmd,
                      input logic [nhhc_pkg::ID_W-1:0] nd,
                      input logic [nhhc_pkg::ID_W-1:0] dst,
                      input logic [nhhc_pkg::ID_W-1:0] hop);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.command <= cmd;
    req.node <= nd;
    req.destination <= dst;
    req.next_hop <= hop;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic apply_node_count(input logic [nhhc_pkg::ID_W-1:0] value);
    logic [nhhc_pkg::APB_DATA_W-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {nhhc_pkg::REG_NODE_COUNT, 2'b00};
    pwdata <= nhhc_pkg::APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.node_count = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== nhhc_pkg::APB_DATA_W'(value)) begin
      $display("%0t: node_count readback expected %0d actual %0d", $time, value, rd);
      sb.failures++;
    end
  endtask

  task automatic random_item();
    int                         n;
    int                         span;
    int                         pick;
    logic [nhhc_pkg::CMD_W-1:0] cmd;
    logic [nhhc_pkg::ID_W-1:0]  nd, dst, hop;
    n = sb.limit();
    span = ($urandom_range(1) == 1 || n < 8) ? n : 8;
    nd = nhhc_pkg::ID_W'($urandom_range(1, span));
    dst = nhhc_pkg::ID_W'($urandom_range(1, span));
    hop = nhhc_pkg::ID_W'($urandom_range(1, span));
    pick = $urandom_range(99);
    if (pick < 12) begin
      // broken items: any command, any id
      cmd = nhhc_pkg::CMD_W'($urandom_range(7));
      nd = nhhc_pkg::ID_W'($urandom_range(127));
      dst = nhhc_pkg::ID_W'($urandom_range(127));
      hop = nhhc_pkg::ID_W'($urandom_range(127));
    end else if (pick < 25) begin
      cmd = nhhc_pkg::CMD_SET_DEFAULT;
      if ($urandom_range(9) == 0) hop = '0;
    end else if (pick < 35) begin
      cmd = nhhc_pkg::CMD_CLEAR_DEFAULT;
      if ($urandom_range(1) == 1) hop = sb.default_at(nd);
    end else if (pick < 58) begin
      cmd = nhhc_pkg::CMD_ADD_ROUTE;
    end else if (pick < 68) begin
      cmd = nhhc_pkg::CMD_REMOVE_ROUTE;
      if ($urandom_range(1) == 1) hop = sb.route_at(nd, dst);
    end else begin
      cmd = nhhc_pkg::CMD_HOP_QUERY;
    end
    send(cmd, nd, dst, hop);
  endtask

  initial begin
    int nc_set [5];
    int item_set [5];
    int src_set [5];
    int sink_set [5];
    nc_set = '{8, 1, 64, 3, 16};
    item_set = '{230, 40, 250, 60, 250};
    src_set = '{9, 9, 85, 85, 0};
    sink_set = '{85, 85, 9, 9, 0};
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req.valid <= 1'b0;
    req.command <= nhhc_pkg::CMD_SET_DEFAULT;
    req.node <= '0;
    req.destination <= '0;
    req.next_hop <= '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // full size: self query at the top id, entries that go stale later
    send(nhhc_pkg::CMD_HOP_QUERY, 7'd64, 7'd64, 7'd0);
    send(nhhc_pkg::CMD_SET_DEFAULT, 7'd64, 7'd0, 7'd64);
    send(nhhc_pkg::CMD_ADD_ROUTE, 7'd1, 7'd3, 7'd40);
    wait_drained();
    apply_node_count(7'd8);

    send(nhhc_pkg::CMD_HOP_QUERY, 7'd1, 7'd64, 7'd0);
    send(nhhc_pkg::CMD_HOP_QUERY, 7'd1, 7'd1, 7'd0);
    send(nhhc_pkg::CMD_HOP_QUERY, 7'd1, 7'd3, 7'd0);
    send(nhhc_pkg::CMD_SET_DEFAULT, 7'd0, 7'd0, 7'd1);
    send(nhhc_pkg::CMD_ADD_ROUTE, 7'd9, 7'd1, 7'd2);
    // chain 1 -> 2 -> 4 -> 5 through defaults and one route
    send(nhhc_pkg::CMD_SET_DEFAULT, 7'd1, 7'd0, 7'd2);
    send(nhhc_pkg::CMD_ADD_ROUTE, 7'd2, 7'd5, 7'd4);
    send(nhhc_pkg::CMD_SET_DEFAULT, 7'd4, 7'd0, 7'd5);
    send(nhhc_pkg::CMD_HOP_QUERY, 7'd1, 7'd5, 7'd0);
    send(nhhc_pkg::CMD_ADD_ROUTE, 7'd2, 7'd5, 7'd3);
    send(nhhc_pkg::CMD_ADD_ROUTE, 7'd2, 7'd0, 7'd3);
    send(nhhc_pkg::CMD_REMOVE_ROUTE, 7'd2, 7'd5, 7'd3);
    send(nhhc_pkg::CMD_REMOVE_ROUTE, 7'd2, 7'd5, 7'd4);
    send(nhhc_pkg::CMD_HOP_QUERY, 7'd1, 7'd5, 7'd0);
    send(nhhc_pkg::CMD_CLEAR_DEFAULT, 7'd1, 7'd0, 7'd3);
    send(nhhc_pkg::CMD_CLEAR_DEFAULT, 7'd6, 7'd0, 7'd0);
    // two-node loop
    send(nhhc_pkg::CMD_SET_DEFAULT, 7'd6, 7'd0, 7'd7);
    send(nhhc_pkg::CMD_SET_DEFAULT, 7'd7, 7'd0, 7'd6);
    send(nhhc_pkg::CMD_HOP_QUERY, 7'd6, 7'd8, 7'd0);
    send(nhhc_pkg::CMD_SET_DEFAULT, 7'd7, 7'd0, 7'd100);
    send(nhhc_pkg::CMD_CLEAR_DEFAULT, 7'd4, 7'd0, 7'd5);
    send(nhhc_pkg::CMD_W'(5), 7'd127, 7'd127, 7'd127);
    send(nhhc_pkg::CMD_W'(6), 7'd127, 7'd127, 7'd127);
    send(nhhc_pkg::CMD_W'(7), 7'd127, 7'd127, 7'd127);
    send(nhhc_pkg::CMD_HOP_QUERY, 7'd0, 7'd3, 7'd0);

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      repeat (4) @(negedge clk);
      apply_node_count(nhhc_pkg::ID_W'(nc_set[p]));
      src_idle_pct = src_set[p];
      sink_idle_pct = sink_set[p];
      for (int i = 0; i < item_set[p]; i++) begin
        if (p == 0 && i == 100) stall_request = 1;
        if (p == 4 && i == 120) wait_drained();
        random_item();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
